FILE: design/ecpa_pkg.sv
// Shared types, constants and the operation sequence for the elliptic curve point adder.
package ecpa_pkg;

   localparam int FIELD_BITS = 32;
   localparam int BIT_IDX_W  = $clog2(FIELD_BITS);
   localparam int CSR_IDX_W  = 2;
   localparam int PC_W       = 6;
   localparam int STATUS_W   = 2;

   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [PC_W-1:0]       pc_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_PRIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_A     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_B     = 2'd2;

   localparam field_type PRIME_RESET   = 32'd223;
   localparam field_type CURVE_A_RESET = 32'd0;
   localparam field_type CURVE_B_RESET = 32'd7;

   // Status codes of a result.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CURVE = 2'd2;

   // Datapath operand and destination selects.
   typedef enum logic [3:0] {
      REG_X1, REG_Y1, REG_X2, REG_Y2, REG_A, REG_B,
      REG_T0, REG_T1, REG_T2, REG_T3
   } reg_sel_type;

   // Operations that the controller issues to the datapath.
   typedef enum logic [2:0] {
      OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_ONE, OP_RES
   } op_type;

   // Kinds of result that the datapath can form.
   typedef enum logic [2:0] {
      RES_ERR_RANGE, RES_ERR_CURVE, RES_INF, RES_FIRST, RES_SECOND, RES_CALC
   } res_type;

   // Instructions of the stored sequence.
   typedef enum logic [2:0] {
      INS_ADD, INS_SUB, INS_MUL, INS_INV, INS_CHK, INS_END
   } ins_type;

   typedef struct packed {
      ins_type     op;
      reg_sel_type dst;
      reg_sel_type src_a;
      reg_sel_type src_b;
   } instr_type;

   typedef struct packed {
      op_type                 op;
      reg_sel_type            dst;
      reg_sel_type            src_a;
      reg_sel_type            src_b;
      logic [BIT_IDX_W-1:0]   bit_sel;
      res_type                res;
   } cmd_type;

   typedef struct packed {
      logic range_bad;
      logic operands_eq;
      logic same_x;
      logic same_y;
      logic first_y_zero;
      logic first_inf;
      logic second_inf;
      logic exp_bit;
      logic mul_done;
   } stat_type;

   // Entry points of the sequences.
   localparam pc_type PC_CURVE1  = 6'd0;
   localparam pc_type PC_CURVE2  = 6'd8;
   localparam pc_type PC_CHORD   = 6'd16;
   localparam pc_type PC_TANGENT = 6'd27;

   function automatic instr_type ins(input ins_type op, input reg_sel_type dst,
                                     input reg_sel_type src_a, input reg_sel_type src_b);
      instr_type r;
      r.op    = op;
      r.dst   = dst;
      r.src_a = src_a;
      r.src_b = src_b;
      return r;
   endfunction

   // Sequence store: curve checks of both points, then chord and tangent slopes.
   // Both slope sequences leave the sum x in T1 and the sum y in T2.
   function automatic instr_type prog_rom(input pc_type pc);
      instr_type r;
      case (pc)
         // y1^2 against x1^3 + a x1 + b
         6'd0:  r = ins(INS_MUL, REG_T0, REG_Y1, REG_Y1);
         6'd1:  r = ins(INS_MUL, REG_T1, REG_X1, REG_X1);
         6'd2:  r = ins(INS_MUL, REG_T1, REG_T1, REG_X1);
         6'd3:  r = ins(INS_MUL, REG_T2, REG_A,  REG_X1);
         6'd4:  r = ins(INS_ADD, REG_T1, REG_T1, REG_T2);
         6'd5:  r = ins(INS_ADD, REG_T1, REG_T1, REG_B);
         6'd6:  r = ins(INS_CHK, REG_T0, REG_T0, REG_T1);
         6'd7:  r = ins(INS_END, REG_T0, REG_T0, REG_T0);
         // y2^2 against x2^3 + a x2 + b
         6'd8:  r = ins(INS_MUL, REG_T0, REG_Y2, REG_Y2);
         6'd9:  r = ins(INS_MUL, REG_T1, REG_X2, REG_X2);
         6'd10: r = ins(INS_MUL, REG_T1, REG_T1, REG_X2);
         6'd11: r = ins(INS_MUL, REG_T2, REG_A,  REG_X2);
         6'd12: r = ins(INS_ADD, REG_T1, REG_T1, REG_T2);
         6'd13: r = ins(INS_ADD, REG_T1, REG_T1, REG_B);
         6'd14: r = ins(INS_CHK, REG_T0, REG_T0, REG_T1);
         6'd15: r = ins(INS_END, REG_T0, REG_T0, REG_T0);
         // Chord slope
         6'd16: r = ins(INS_SUB, REG_T0, REG_Y2, REG_Y1);
         6'd17: r = ins(INS_SUB, REG_T1, REG_X2, REG_X1);
         6'd18: r = ins(INS_INV, REG_T3, REG_T1, REG_T1);
         6'd19: r = ins(INS_MUL, REG_T0, REG_T0, REG_T3);
         6'd20: r = ins(INS_MUL, REG_T1, REG_T0, REG_T0);
         6'd21: r = ins(INS_SUB, REG_T1, REG_T1, REG_X1);
         6'd22: r = ins(INS_SUB, REG_T1, REG_T1, REG_X2);
         6'd23: r = ins(INS_SUB, REG_T2, REG_X1, REG_T1);
         6'd24: r = ins(INS_MUL, REG_T2, REG_T0, REG_T2);
         6'd25: r = ins(INS_SUB, REG_T2, REG_T2, REG_Y1);
         6'd26: r = ins(INS_END, REG_T0, REG_T0, REG_T0);
         // Tangent slope
         6'd27: r = ins(INS_MUL, REG_T0, REG_X1, REG_X1);
         6'd28: r = ins(INS_ADD, REG_T1, REG_T0, REG_T0);
         6'd29: r = ins(INS_ADD, REG_T1, REG_T1, REG_T0);
         6'd30: r = ins(INS_ADD, REG_T1, REG_T1, REG_A);
         6'd31: r = ins(INS_ADD, REG_T2, REG_Y1, REG_Y1);
         6'd32: r = ins(INS_INV, REG_T3, REG_T2, REG_T2);
         6'd33: r = ins(INS_MUL, REG_T0, REG_T1, REG_T3);
         6'd34: r = ins(INS_MUL, REG_T1, REG_T0, REG_T0);
         6'd35: r = ins(INS_ADD, REG_T2, REG_X1, REG_X1);
         6'd36: r = ins(INS_SUB, REG_T1, REG_T1, REG_T2);
         6'd37: r = ins(INS_SUB, REG_T2, REG_X1, REG_T1);
         6'd38: r = ins(INS_MUL, REG_T2, REG_T0, REG_T2);
         6'd39: r = ins(INS_SUB, REG_T2, REG_T2, REG_Y1);
         default: r = ins(INS_END, REG_T0, REG_T0, REG_T0);
      endcase
      return r;
   endfunction

endpackage

FILE: design/ecpa_if.sv
// Request and response channel interfaces of the point adder.
interface ecpa_req_if;
   import ecpa_pkg::*;
   logic      valid;
   logic      ready;
   field_type first_x;
   field_type first_y;
   logic      first_infinity;
   field_type second_x;
   field_type second_y;
   logic      second_infinity;

   modport source (output valid, first_x, first_y, first_infinity,
                   second_x, second_y, second_infinity, input ready);
   modport sink   (input valid, first_x, first_y, first_infinity,
                   second_x, second_y, second_infinity, output ready);
endinterface

interface ecpa_rsp_if;
   import ecpa_pkg::*;
   logic                valid;
   logic                ready;
   field_type           sum_x;
   field_type           sum_y;
   logic                sum_infinity;
   logic [STATUS_W-1:0] status;

   modport source (output valid, sum_x, sum_y, sum_infinity, status, input ready);
   modport sink   (input valid, sum_x, sum_y, sum_infinity, status, output ready);
endinterface

FILE: design/ec_point_add_prime_field.sv
// Top level of the affine elliptic curve point adder over a prime field.
//
//   Channel   Direction  Handshake          Carries
//   req_bus   in         valid / ready      two affine points with infinity flags
//   rsp_bus   out        valid / ready      sum point, infinity flag and status
//   csr_*     in         write enable only  field prime, curve a, curve b
//
// One request is worked on at a time; error and trivial cases finish soonest, and
// a request takes longest when a slope is computed. The bit-serial modular multiplier
// dominates: each product is an issue, 32 bit steps and a write-back, and a request
// needs up to 76 products, 64 of them in the Fermat inversion.
// The result waits in an output register, so a new request is taken while the
// previous response is still stalled. Reset is synchronous and active high.
module ec_point_add_prime_field (
   input  logic                            clock,
   input  logic                            reset,
   ecpa_req_if.sink                        req_bus,
   ecpa_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [ecpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  ecpa_pkg::field_type             csr_wdata
);
   import ecpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ecpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ecpa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_first_x         (req_bus.first_x),
      .req_first_y         (req_bus.first_y),
      .req_first_infinity  (req_bus.first_infinity),
      .req_second_x        (req_bus.second_x),
      .req_second_y        (req_bus.second_y),
      .req_second_infinity (req_bus.second_infinity),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_sum_x           (rsp_bus.sum_x),
      .rsp_sum_y           (rsp_bus.sum_y),
      .rsp_sum_infinity    (rsp_bus.sum_infinity),
      .rsp_status          (rsp_bus.status)
   );

endmodule

FILE: design/ecpa_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, most significant first.
module ecpa_modmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ecpa_pkg::field_type u,
   input  ecpa_pkg::field_type v,
   input  ecpa_pkg::field_type p,
   output logic               done,
   output ecpa_pkg::field_type product
);
   import ecpa_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BIT_IDX_W-1:0] cnt_ff, cnt_in;
   field_type            acc_ff, acc_in;
   field_type            mcand_ff, mcand_in;
   field_type            mplier_ff, mplier_in;
   logic [FIELD_BITS:0]  dbl_sum, add_sum;
   field_type            dbl_red, add_red;

   // One step: double the partial result, then add the multiplicand on a set bit.
   always_comb begin
      dbl_sum = {acc_ff, 1'b0};
      dbl_red = (dbl_sum >= {1'b0, p}) ? FIELD_BITS'(dbl_sum - {1'b0, p})
                                       : FIELD_BITS'(dbl_sum);
      add_sum = {1'b0, dbl_red} + {1'b0, mcand_ff};
      add_red = (add_sum >= {1'b0, p}) ? FIELD_BITS'(add_sum - {1'b0, p})
                                       : FIELD_BITS'(add_sum);
   end

   // Sequencing of the bit steps.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '1;
         acc_in    = '0;
         mcand_in  = u;
         mplier_in = v;
      end else if (busy_ff) begin
         acc_in    = mplier_ff[FIELD_BITS-1] ? add_red : dbl_red;
         mplier_in = {mplier_ff[FIELD_BITS-2:0], 1'b0};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: design/ecpa_datapath.sv
// Datapath: configuration registers, operand registers, field adder and subtractor,
// multiplier and the result register.
module ecpa_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ecpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  ecpa_pkg::field_type              csr_wdata,
   input  ecpa_pkg::field_type              req_first_x,
   input  ecpa_pkg::field_type              req_first_y,
   input  logic                             req_first_infinity,
   input  ecpa_pkg::field_type              req_second_x,
   input  ecpa_pkg::field_type              req_second_y,
   input  logic                             req_second_infinity,
   input  ecpa_pkg::cmd_type                cmd,
   output ecpa_pkg::stat_type               stat,
   output ecpa_pkg::field_type              rsp_sum_x,
   output ecpa_pkg::field_type              rsp_sum_y,
   output logic                             rsp_sum_infinity,
   output logic [ecpa_pkg::STATUS_W-1:0]    rsp_status
);
   import ecpa_pkg::*;

   field_type prime_ff, curve_a_ff, curve_b_ff;
   field_type x1_ff, y1_ff, x2_ff, y2_ff;
   logic      inf1_ff, inf2_ff;
   field_type t0_ff, t1_ff, t2_ff, t3_ff;
   field_type sum_x_ff, sum_y_ff;
   logic      sum_inf_ff;
   logic [STATUS_W-1:0] status_ff;

   field_type           opa, opb, wr_data, exp_val, mul_product;
   logic                wr_en;
   logic                mul_done;
   logic [FIELD_BITS:0] add_sum;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff   <= PRIME_RESET;
         curve_a_ff <= CURVE_A_RESET;
         curve_b_ff <= CURVE_B_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIELD_PRIME: prime_ff   <= csr_wdata;
            CSR_CURVE_A:     curve_a_ff <= csr_wdata;
            CSR_CURVE_B:     curve_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Operand selection.
   function automatic field_type pick(input reg_sel_type sel, input field_type x1,
                                      input field_type y1, input field_type x2,
                                      input field_type y2, input field_type ca,
                                      input field_type cb, input field_type t0,
                                      input field_type t1, input field_type t2,
                                      input field_type t3);
      field_type r;
      case (sel)
         REG_X1:  r = x1;
         REG_Y1:  r = y1;
         REG_X2:  r = x2;
         REG_Y2:  r = y2;
         REG_A:   r = ca;
         REG_B:   r = cb;
         REG_T0:  r = t0;
         REG_T1:  r = t1;
         REG_T2:  r = t2;
         REG_T3:  r = t3;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign opa = pick(cmd.src_a, x1_ff, y1_ff, x2_ff, y2_ff, curve_a_ff, curve_b_ff,
                     t0_ff, t1_ff, t2_ff, t3_ff);
   assign opb = pick(cmd.src_b, x1_ff, y1_ff, x2_ff, y2_ff, curve_a_ff, curve_b_ff,
                     t0_ff, t1_ff, t2_ff, t3_ff);

   ecpa_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.op == OP_MUL),
      .u       (opa),
      .v       (opb),
      .p       (prime_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // Field addition, subtraction and the write-back value.
   always_comb begin
      add_sum = {1'b0, opa} + {1'b0, opb};
      wr_en   = 1'b0;
      wr_data = '0;
      if (mul_done) begin
         wr_en   = 1'b1;
         wr_data = mul_product;
      end else begin
         case (cmd.op)
            OP_ADD: begin
               wr_en   = 1'b1;
               wr_data = (add_sum >= {1'b0, prime_ff})
                         ? FIELD_BITS'(add_sum - {1'b0, prime_ff})
                         : FIELD_BITS'(add_sum);
            end
            OP_SUB: begin
               wr_en   = 1'b1;
               wr_data = (opa >= opb) ? opa - opb : opa + (prime_ff - opb);
            end
            OP_ONE: begin
               wr_en   = 1'b1;
               wr_data = (prime_ff > field_type'(1)) ? field_type'(1) : '0;
            end
            default: ;
         endcase
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         x1_ff   <= req_first_x;
         y1_ff   <= req_first_y;
         inf1_ff <= req_first_infinity;
         x2_ff   <= req_second_x;
         y2_ff   <= req_second_y;
         inf2_ff <= req_second_infinity;
      end
      if (wr_en && cmd.dst == REG_T0) t0_ff <= wr_data;
      if (wr_en && cmd.dst == REG_T1) t1_ff <= wr_data;
      if (wr_en && cmd.dst == REG_T2) t2_ff <= wr_data;
      if (wr_en && cmd.dst == REG_T3) t3_ff <= wr_data;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RES) begin
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
         sum_inf_ff <= 1'b0;
         status_ff  <= STATUS_OK;
         case (cmd.res)
            RES_ERR_RANGE: status_ff  <= STATUS_RANGE;
            RES_ERR_CURVE: status_ff  <= STATUS_CURVE;
            RES_INF:       sum_inf_ff <= 1'b1;
            RES_FIRST: begin
               sum_x_ff <= x1_ff;
               sum_y_ff <= y1_ff;
            end
            RES_SECOND: begin
               sum_x_ff <= x2_ff;
               sum_y_ff <= y2_ff;
            end
            RES_CALC: begin
               sum_x_ff <= t1_ff;
               sum_y_ff <= t2_ff;
            end
            default: ;
         endcase
      end
   end

   // Status towards the controller.
   assign exp_val = prime_ff - field_type'(2);

   always_comb begin
      stat.range_bad    = (curve_a_ff >= prime_ff) || (curve_b_ff >= prime_ff)
                       || (!inf1_ff && (x1_ff >= prime_ff || y1_ff >= prime_ff))
                       || (!inf2_ff && (x2_ff >= prime_ff || y2_ff >= prime_ff));
      stat.operands_eq  = (opa == opb);
      stat.same_x       = (x1_ff == x2_ff);
      stat.same_y       = (y1_ff == y2_ff);
      stat.first_y_zero = (y1_ff == '0);
      stat.first_inf    = inf1_ff;
      stat.second_inf   = inf2_ff;
      stat.exp_bit      = exp_val[cmd.bit_sel];
      stat.mul_done     = mul_done;
   end

   assign rsp_sum_x        = sum_x_ff;
   assign rsp_sum_y        = sum_y_ff;
   assign rsp_sum_infinity = sum_inf_ff;
   assign rsp_status       = status_ff;

endmodule

FILE: design/ecpa_ctrl.sv
// Controller: case selection, sequence stepping, inversion loop and response handshake.
module ecpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ecpa_pkg::stat_type stat,
   output ecpa_pkg::cmd_type  cmd
);
   import ecpa_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_ROUTE   = 9'b000000010,
      ST_FETCH   = 9'b000000100,
      ST_MULW    = 9'b000001000,
      ST_INV_SQ  = 9'b000010000,
      ST_INV_SQW = 9'b000100000,
      ST_INV_ML  = 9'b001000000,
      ST_INV_MLW = 9'b010000000,
      ST_FINISH  = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   pc_type               pc_ff, pc_in;
   logic [BIT_IDX_W-1:0] cnt_ff, cnt_in;
   logic                 chk1_ff, chk1_in;
   logic                 chk2_ff, chk2_in;
   logic                 calc_ff, calc_in;
   logic                 off_ff, off_in;
   res_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   instr_type            instr;
   logic                 inv_next;

   assign instr = prog_rom(pc_ff);

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      chk1_in      = chk1_ff;
      chk2_in      = chk2_ff;
      calc_in      = calc_ff;
      off_in       = off_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      inv_next     = 1'b0;
      cmd.op       = OP_NOP;
      cmd.dst      = instr.dst;
      cmd.src_a    = instr.src_a;
      cmd.src_b    = instr.src_b;
      cmd.bit_sel  = cnt_ff;
      cmd.res      = res_ff;

      case (state_ff)
         // Take a request and clear the progress flags.
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               chk1_in  = 1'b0;
               chk2_in  = 1'b0;
               calc_in  = 1'b0;
               off_in   = 1'b0;
               state_in = ST_ROUTE;
            end
         end

         // Pick the next sequence or the kind of result.
         ST_ROUTE: begin
            state_in = ST_FINISH;
            if (stat.range_bad) begin
               res_in = RES_ERR_RANGE;
            end else if (!chk1_ff) begin
               chk1_in  = 1'b1;
               state_in = ST_ROUTE;
               if (!stat.first_inf) begin
                  pc_in    = PC_CURVE1;
                  state_in = ST_FETCH;
               end
            end else if (!chk2_ff) begin
               chk2_in  = 1'b1;
               state_in = ST_ROUTE;
               if (!stat.second_inf) begin
                  pc_in    = PC_CURVE2;
                  state_in = ST_FETCH;
               end
            end else if (off_ff) begin
               res_in = RES_ERR_CURVE;
            end else if (stat.first_inf && stat.second_inf) begin
               res_in = RES_INF;
            end else if (stat.first_inf) begin
               res_in = RES_SECOND;
            end else if (stat.second_inf) begin
               res_in = RES_FIRST;
            end else if (stat.same_x && !stat.same_y) begin
               res_in = RES_INF;
            end else if (calc_ff) begin
               res_in = RES_CALC;
            end else if (!stat.same_x) begin
               calc_in  = 1'b1;
               pc_in    = PC_CHORD;
               state_in = ST_FETCH;
            end else if (stat.first_y_zero) begin
               res_in = RES_INF;
            end else begin
               calc_in  = 1'b1;
               pc_in    = PC_TANGENT;
               state_in = ST_FETCH;
            end
         end

         // Issue one instruction of the sequence.
         ST_FETCH: begin
            case (instr.op)
               INS_ADD: begin
                  cmd.op = OP_ADD;
                  pc_in  = pc_ff + 1'b1;
               end
               INS_SUB: begin
                  cmd.op = OP_SUB;
                  pc_in  = pc_ff + 1'b1;
               end
               INS_MUL: begin
                  cmd.op   = OP_MUL;
                  state_in = ST_MULW;
               end
               INS_INV: begin
                  cmd.op   = OP_ONE;
                  cmd.dst  = REG_T3;
                  cnt_in   = '1;
                  state_in = ST_INV_SQ;
               end
               INS_CHK: begin
                  if (!stat.operands_eq) off_in = 1'b1;
                  pc_in = pc_ff + 1'b1;
               end
               INS_END: state_in = ST_ROUTE;
               default: state_in = ST_ROUTE;
            endcase
         end

         ST_MULW: begin
            if (stat.mul_done) begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end

         // Square-and-multiply over the bits of p - 2, result in T3.
         ST_INV_SQ: begin
            cmd.op    = OP_MUL;
            cmd.dst   = REG_T3;
            cmd.src_a = REG_T3;
            cmd.src_b = REG_T3;
            state_in  = ST_INV_SQW;
         end

         ST_INV_SQW: begin
            cmd.dst = REG_T3;
            if (stat.mul_done) begin
               if (stat.exp_bit) state_in = ST_INV_ML;
               else              inv_next = 1'b1;
            end
         end

         ST_INV_ML: begin
            cmd.op    = OP_MUL;
            cmd.dst   = REG_T3;
            cmd.src_a = REG_T3;
            cmd.src_b = instr.src_a;
            state_in  = ST_INV_MLW;
         end

         ST_INV_MLW: begin
            cmd.dst = REG_T3;
            if (stat.mul_done) inv_next = 1'b1;
         end

         // Load the result register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RES;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Next exponent bit, or leave the inversion.
      if (inv_next) begin
         if (cnt_ff == '0) begin
            pc_in    = pc_ff + 1'b1;
            state_in = ST_FETCH;
         end else begin
            cnt_in   = cnt_ff - 1'b1;
            state_in = ST_INV_SQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pc_ff   <= pc_in;
      cnt_ff  <= cnt_in;
      chk1_ff <= chk1_in;
      chk2_ff <= chk2_in;
      calc_ff <= calc_in;
      off_ff  <= off_in;
      res_ff  <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: bench/ecpa_sum_checker.sv
// Checker of the point adder: predicts every sum from the accepted requests and compares.
module ecpa_sum_checker
   import ecpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ecpa_req_if                  req_bus,
   ecpa_rsp_if                  rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  field_type            csr_wdata,
   output int                   fail_count,
   output int                   pending_sums
);

   typedef struct packed {
      field_type           x;
      field_type           y;
      logic                inf;
      logic [STATUS_W-1:0] status;
   } sum_type;

   field_type prime_q, coef_a, coef_b;
   sum_type   sum_queue[$];

   // Modular addition with the carry kept, so no sum wraps.
   function automatic field_type mod_add(field_type u, field_type v, field_type p);
      logic [FIELD_BITS:0] s;
      s = {1'b0, u} + {1'b0, v};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
      return s[FIELD_BITS-1:0];
   endfunction

   function automatic field_type mod_sub(field_type u, field_type v, field_type p);
      if (u >= v) return u - v;
      return u + (p - v);
   endfunction

   function automatic field_type mod_mul(field_type u, field_type v, field_type p);
      field_type r;
      r = '0;
      for (int i = FIELD_BITS - 1; i >= 0; i--) begin
         r = mod_add(r, r, p);
         if (v[i]) r = mod_add(r, u, p);
      end
      return r;
   endfunction

   // Fermat inversion by square-and-multiply over all exponent bits.
   function automatic field_type mod_inv(field_type u, field_type p);
      field_type e, r;
      e = p - 2;
      r = (p > 1) ? 1 : 0;
      for (int i = FIELD_BITS - 1; i >= 0; i--) begin
         r = mod_mul(r, r, p);
         if (e[i]) r = mod_mul(r, u, p);
      end
      return r;
   endfunction

   function automatic logic point_on_curve(field_type x, field_type y, field_type p,
                                           field_type a, field_type b);
      field_type rhs;
      rhs = mod_mul(mod_mul(x, x, p), x, p);
      rhs = mod_add(rhs, mod_mul(a, x, p), p);
      rhs = mod_add(rhs, b, p);
      return mod_mul(y, y, p) == rhs;
   endfunction

   function automatic sum_type point_sum(field_type x1, field_type y1, logic i1,
                                         field_type x2, field_type y2, logic i2);
      sum_type   r;
      field_type p, s, n, xx;
      logic      bad;
      p   = prime_q;
      r   = '0;
      bad = coef_a >= p || coef_b >= p;
      if (!i1 && (x1 >= p || y1 >= p)) bad = 1'b1;
      if (!i2 && (x2 >= p || y2 >= p)) bad = 1'b1;
      if (bad) begin
         r.status = STATUS_RANGE;
      end else if ((!i1 && !point_on_curve(x1, y1, p, coef_a, coef_b)) ||
                   (!i2 && !point_on_curve(x2, y2, p, coef_a, coef_b))) begin
         r.status = STATUS_CURVE;
      end else if (i1 && i2) begin
         r.inf = 1'b1;
      end else if (i1) begin
         r.x = x2;
         r.y = y2;
      end else if (i2) begin
         r.x = x1;
         r.y = y1;
      end else if (x1 == x2 && y1 != y2) begin
         r.inf = 1'b1;
      end else if (x1 != x2) begin
         s   = mod_mul(mod_sub(y2, y1, p), mod_inv(mod_sub(x2, x1, p), p), p);
         r.x = mod_sub(mod_sub(mod_mul(s, s, p), x1, p), x2, p);
         r.y = mod_sub(mod_mul(s, mod_sub(x1, r.x, p), p), y1, p);
      end else if (y1 == 0) begin
         r.inf = 1'b1;
      end else begin
         xx  = mod_mul(x1, x1, p);
         n   = mod_add(mod_add(mod_add(xx, xx, p), xx, p), coef_a, p);
         s   = mod_mul(n, mod_inv(mod_add(y1, y1, p), p), p);
         r.x = mod_sub(mod_mul(s, s, p), mod_add(x1, x1, p), p);
         r.y = mod_sub(mod_mul(s, mod_sub(x1, r.x, p), p), y1, p);
      end
      return r;
   endfunction

   assign pending_sums = sum_queue.size();

   // Track the registers, queue a prediction per request, compare each response.
   always @(posedge clock) begin
      sum_type want;
      if (reset) begin
         prime_q    <= PRIME_RESET;
         coef_a     <= CURVE_A_RESET;
         coef_b     <= CURVE_B_RESET;
         fail_count <= 0;
         sum_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIELD_PRIME: prime_q <= csr_wdata;
               CSR_CURVE_A:     coef_a  <= csr_wdata;
               CSR_CURVE_B:     coef_b  <= csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            sum_queue.push_back(point_sum(req_bus.first_x, req_bus.first_y,
               req_bus.first_infinity, req_bus.second_x, req_bus.second_y,
               req_bus.second_infinity));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sum_queue.size() == 0) begin
               if (fail_count < 10) $display("Unexpected response at %0t", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = sum_queue.pop_front();
               if (want.x !== rsp_bus.sum_x || want.y !== rsp_bus.sum_y ||
                   want.inf !== rsp_bus.sum_infinity || want.status !== rsp_bus.status) begin
                  if (fail_count < 10)
                     $display("Mismatch at %0t: expected x=%h y=%h inf=%b st=%0d, got x=%h y=%h inf=%b st=%0d",
                        $time, want.x, want.y, want.inf, want.status, rsp_bus.sum_x,
                        rsp_bus.sum_y, rsp_bus.sum_infinity, rsp_bus.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: bench/tb_ec_point_add_prime_field.sv
// Testbench top of the point adder: stimulus, register settings and the verdict.
module tb_ec_point_add_prime_field;
   import ecpa_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   field_type            csr_wdata;
   int                   fail_count;
   int                   pending_sums;
   int                   cycle_count;
   int                   send_idle_pct;
   int                   stall_pct;
   field_type            cur_p, cur_a, cur_b;

   ecpa_req_if req_bus ();
   ecpa_rsp_if rsp_bus ();

   ec_point_add_prime_field u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   ecpa_sum_checker u_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_sums(pending_sums));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver stalls at random.
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, field_type val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_curve(field_type p, field_type a, field_type b);
      write_reg(CSR_FIELD_PRIME, p);
      write_reg(CSR_CURVE_A, a);
      write_reg(CSR_CURVE_B, b);
      cur_p = p;
      cur_a = a;
      cur_b = b;
   endtask

   // Sends one request, with a random gap beforehand. The request is raised on a later
   // falling edge than the call's own, so valid is never dropped and raised in one step.
   task automatic send_points(field_type x1, field_type y1, logic i1,
                              field_type x2, field_type y2, logic i2);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_bus.valid           <= 1'b1;
      req_bus.first_x         <= x1;
      req_bus.first_y         <= y1;
      req_bus.first_infinity  <= i1;
      req_bus.second_x        <= x2;
      req_bus.second_y        <= y2;
      req_bus.second_infinity <= i2;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Searches a random point on the current curve; y may be zero on some curves.
   task automatic curve_point(output field_type x, output field_type y);
      field_type rhs, t;
      for (int k = 0; k < 400; k++) begin
         x   = ($urandom % cur_p);
         rhs = u_checker.mod_add(u_checker.mod_add(u_checker.mod_mul(
                  u_checker.mod_mul(x, x, cur_p), x, cur_p),
                  u_checker.mod_mul(cur_a, x, cur_p), cur_p), cur_b, cur_p);
         if (cur_p < 300) begin
            for (int c = 0; c < cur_p; c++) begin
               t = c;
               if (u_checker.mod_mul(t, t, cur_p) == rhs) begin
                  y = ($urandom_range(1) && t != 0) ? cur_p - t : t;
                  return;
               end
            end
         end else if (cur_p % 4 == 3) begin
            t = u_checker.mod_inv(1, cur_p);
            // Square root by exponent (p+1)/4.
            t = 1;
            for (int i = FIELD_BITS - 1; i >= 0; i--) begin
               t = u_checker.mod_mul(t, t, cur_p);
               if (((cur_p >> 2) + 1) >> i & 1) t = u_checker.mod_mul(t, rhs, cur_p);
            end
            if (u_checker.mod_mul(t, t, cur_p) == rhs) begin
               y = $urandom_range(1) ? cur_p - t : t;
               if (y == cur_p) y = 0;
               return;
            end
         end
      end
      x = 0;
      y = 0;
   endtask

   // Random requests, mostly of valid points with some noise.
   task automatic random_phase(int count, int idle, int stall);
      field_type x1, y1, x2, y2;
      int        kind;
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         curve_point(x1, y1);
         curve_point(x2, y2);
         kind = $urandom_range(99);
         if (kind < 15) begin
            x2 = x1; y2 = y1;
         end else if (kind < 25) begin
            x2 = x1; y2 = (y1 == 0) ? 0 : cur_p - y1;
         end else if (kind < 33) begin
            x1 = $urandom; y2 = $urandom;
         end else if (kind < 40) begin
            y1 = u_checker.mod_add(y1, 1, cur_p);
         end
         send_points(x1, y1, $urandom_range(99) < 8, x2, y2, $urandom_range(99) < 8);
      end
      send_idle_pct = 0;
      while (pending_sums != 0) @(negedge clock);
      stall_pct = 0;
      repeat (40) @(negedge clock);
   endtask

   initial begin
      cycle_count             = 0;
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = CSR_FIELD_PRIME;
      csr_wdata               = '0;
      send_idle_pct           = 0;
      stall_pct               = 0;
      cur_p                   = PRIME_RESET;
      cur_a                   = CURVE_A_RESET;
      cur_b                   = CURVE_B_RESET;
      req_bus.valid           = 1'b0;
      req_bus.first_x         = '0;
      req_bus.first_y         = '0;
      req_bus.first_infinity  = 1'b0;
      req_bus.second_x        = '0;
      req_bus.second_y        = '0;
      req_bus.second_infinity = 1'b0;
      rsp_bus.ready           = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset curve y^2 = x^3 + 7 mod 223.
      send_points(0, 0, 1, 0, 0, 1);               // both infinity
      send_points('1, '1, 1, 8, 42, 0);            // first infinity, ignored coordinates
      send_points(8, 42, 0, '1, '1, 1);            // second infinity
      send_points(8, 42, 0, 8, 181, 0);            // point plus its negation
      send_points(8, 42, 0, 8, 42, 0);             // same point twice, off this curve
      send_points(8, 42, 0, 23, 98, 0);            // two points with different x, both off this curve
      send_points(223, 0, 0, 8, 42, 0);            // coordinate equal to the prime
      send_points('1, '1, 0, '1, '1, 0);           // all-ones coordinates
      send_points(1, 1, 0, 8, 42, 0);              // off the curve
      send_points(8, 42, 0, 1, 1, 0);              // second off the curve
      send_points(222, 222, 0, 0, 0, 0);           // largest in-range values
      while (pending_sums != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      // Curve y^2 = x^3 + x with a point of order two, to double y = 0.
      set_curve(223, 1, 0);
      send_points(0, 0, 0, 0, 0, 0);
      send_points(0, 0, 0, 5, 6, 0);
      while (pending_sums != 0) @(negedge clock);
      write_reg(CSR_CURVE_A, 223);                 // coefficient not below the prime
      send_points(0, 0, 1, 0, 0, 1);
      while (pending_sums != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      set_curve(0, 0, 0);                          // prime of zero
      send_points(0, 0, 1, 0, 0, 1);
      while (pending_sums != 0) @(negedge clock);
      set_curve(1, 0, 0);                          // prime of one
      send_points(0, 0, 0, 0, 0, 0);
      while (pending_sums != 0) @(negedge clock);
      set_curve(15, 2, 3);                         // modulus not a prime
      send_points(1, 1, 0, 1, 1, 0);
      send_points(3, 6, 0, 1, 1, 0);
      while (pending_sums != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      // Random phases through several curves and idling patterns.
      set_curve(PRIME_RESET, CURVE_A_RESET, CURVE_B_RESET);
      random_phase(50, 0, 0);
      set_curve(251, 250, 250);
      random_phase(50, 53, 0);
      set_curve(32'hFFFFFFFB, 32'hFFFFFFFA, 32'h0000_0005);
      random_phase(50, 0, 53);
      set_curve(3, 2, 1);
      random_phase(25, 38, 38);
      set_curve(32'h7FFFFFFF, 3, 32'h5A5A5A5A);
      random_phase(25, 38, 38);

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
design/ecpa_pkg.sv
design/ecpa_if.sv
design/ecpa_modmul.sv
design/ecpa_datapath.sv
design/ecpa_ctrl.sv
design/ec_point_add_prime_field.sv
bench/ecpa_sum_checker.sv
bench/tb_ec_point_add_prime_field.sv
